/* rtl/sqvs_pkg.sv */
// Package for the sprite quad vertex setup block: sizes, register indexes,
// the per-vertex pipeline payload and the per-stage arithmetic.
// No dependencies.
package sqvs_pkg;

  localparam int unsigned ANGLE_BITS      = 12;
  localparam int unsigned COORD_FRAC_BITS = 4;

  localparam int unsigned QSIZE  = 1 << (ANGLE_BITS - 2);
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned DEN_W  = SIZE_W + COORD_FRAC_BITS;
  localparam int unsigned REM_W  = DEN_W + 21;
  localparam int unsigned UV_W   = 17;
  localparam int unsigned NSTG   = UV_W + 2;

  localparam logic [UV_W-1:0] UV_MAX = '1;
  localparam logic signed [19:0] COORD_MAX = 20'sh7FFFF;
  localparam logic signed [19:0] COORD_MIN = 20'sh80000;

  typedef enum logic [2:0] {
    REG_TEX_BOUND = 3'd0,
    REG_TEX_WIDTH = 3'd1,
    REG_TEX_HEIGHT = 3'd2,
    REG_FLIP_V    = 3'd3,
    REG_TINT      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]               corner;
    logic signed [20:0]       pxo;
    logic signed [20:0]       pyo;
    logic signed [21:0]       dx;
    logic signed [21:0]       dy;
    logic [14:0]              t_s;
    logic [14:0]              t_c;
    logic [14:0]              t2_s;
    logic [14:0]              t2_c;
    logic [14:0]              acc_s;
    logic [14:0]              acc_c;
    logic                     neg_s;
    logic                     neg_c;
    logic signed [15:0]       sn;
    logic signed [15:0]       cs;
    logic signed [37:0]       p_xc;
    logic signed [37:0]       p_ys;
    logic signed [37:0]       p_xs;
    logic signed [37:0]       p_yc;
    logic signed [24:0]       x_full;
    logic signed [24:0]       y_full;
    logic signed [19:0]       vx;
    logic signed [19:0]       vy;
    logic [REM_W-1:0]         rem_u;
    logic [REM_W-1:0]         rem_v;
    logic [DEN_W-1:0]         den_u;
    logic [DEN_W-1:0]         den_v;
    logic [UV_W-1:0]          q_u;
    logic [UV_W-1:0]          q_v;
    logic                     ovf_u;
    logic                     ovf_v;
  } vtx_t;

  // Quarter-wave argument for one angle: {negate, t in Q1.14}
  function automatic logic [15:0] trig_arg(input logic [ANGLE_BITS-1:0] a);
    logic [1:0]            quad;
    logic [ANGLE_BITS-2:0] rr;
    logic [14:0]           t;
    quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
    rr   = {1'b0, a[ANGLE_BITS-3:0]};
    if (quad[0]) rr = (ANGLE_BITS-1)'(QSIZE) - rr;
    t = 15'(rr) << (16 - ANGLE_BITS);
    return {quad[1], t};
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [24:0] v);
    if (v > 25'(COORD_MAX)) return COORD_MAX;
    if (v < 25'(COORD_MIN)) return COORD_MIN;
    return v[19:0];
  endfunction

  // One divider step: quotient bit j of rem / den
  function automatic void div_step(inout logic [REM_W-1:0] rem,
                                   inout logic [UV_W-1:0] q,
                                   input logic [DEN_W-1:0] den,
                                   input int unsigned j);
    logic [REM_W-1:0] sub;
    sub = REM_W'(den) << j;
    if (rem >= sub) begin
      rem = rem - sub;
      q   = q | (UV_W'(1) << j);
    end
  endfunction

  // Work of pipeline stage idx (2..NSTG) on the payload of the previous stage
  function automatic vtx_t stage_fn(input vtx_t d, input int unsigned idx);
    vtx_t             r;
    logic [29:0]      m_s;
    logic [29:0]      m_c;
    logic [15:0]      s_s;
    logic [15:0]      s_c;
    logic signed [38:0] ex;
    logic signed [38:0] ey;
    logic signed [24:0] rx;
    logic signed [24:0] ry;
    r = d;
    m_s = '0;
    m_c = '0;
    s_s = '0;
    s_c = '0;
    ex = '0;
    ey = '0;
    rx = '0;
    ry = '0;
    case (idx)
      2: begin
        m_s = 30'(d.t_s) * 30'(d.t_s) + 30'd8192;
        m_c = 30'(d.t_c) * 30'(d.t_c) + 30'd8192;
        r.t2_s = m_s[28:14];
        r.t2_c = m_c[28:14];
        r.ovf_u = d.rem_u >= (REM_W'(d.den_u) << UV_W);
        r.ovf_v = d.rem_v >= (REM_W'(d.den_v) << UV_W);
      end
      3: begin
        m_s = 30'(d.t2_s) * 30'd1160 + 30'd8192;
        m_c = 30'(d.t2_c) * 30'd1160 + 30'd8192;
        r.acc_s = 15'd10512 - m_s[28:14];
        r.acc_c = 15'd10512 - m_c[28:14];
      end
      4: begin
        m_s = 30'(d.t2_s) * 30'(d.acc_s) + 30'd8192;
        m_c = 30'(d.t2_c) * 30'(d.acc_c) + 30'd8192;
        r.acc_s = 15'd25736 - m_s[28:14];
        r.acc_c = 15'd25736 - m_c[28:14];
      end
      5: begin
        m_s = 30'(d.t_s) * 30'(d.acc_s) + 30'd8192;
        m_c = 30'(d.t_c) * 30'(d.acc_c) + 30'd8192;
        s_s = (m_s[29:14] > 16'd16384) ? 16'd16384 : m_s[29:14];
        s_c = (m_c[29:14] > 16'd16384) ? 16'd16384 : m_c[29:14];
        r.sn = d.neg_s ? -$signed(s_s) : $signed(s_s);
        r.cs = d.neg_c ? -$signed(s_c) : $signed(s_c);
      end
      6: begin
        r.p_xc = 38'(d.cs) * 38'(d.dx);
        r.p_ys = 38'(d.sn) * 38'(d.dy);
        r.p_xs = 38'(d.sn) * 38'(d.dx);
        r.p_yc = 38'(d.cs) * 38'(d.dy);
      end
      7: begin
        ex = 39'(d.p_xc) - 39'(d.p_ys) + 39'sd8192;
        ey = 39'(d.p_xs) + 39'(d.p_yc) + 39'sd8192;
        rx = 25'(ex >>> 14);
        ry = 25'(ey >>> 14);
        r.x_full = 25'(d.pxo) + rx;
        r.y_full = 25'(d.pyo) + ry;
      end
      8: begin
        r.vx = sat20(d.x_full);
        r.vy = sat20(d.y_full);
      end
      default: ;
    endcase
    if (idx >= 3) begin
      div_step(r.rem_u, r.q_u, d.den_u, NSTG - idx);
      div_step(r.rem_v, r.q_v, d.den_v, NSTG - idx);
    end
    return r;
  endfunction

endpackage

/* rtl/sqvs_in_if.sv */
// Sprite input channel: valid/ready handshake and sprite description.
// Depends on sqvs_pkg.
interface sqvs_in_if;
  import sqvs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [19:0]     pos_x;
  logic signed [19:0]     pos_y;
  logic [15:0]            size_w;
  logic [15:0]            size_h;
  logic signed [19:0]     pivot_x;
  logic signed [19:0]     pivot_y;
  logic [ANGLE_BITS-1:0]  angle;
  logic [15:0]            src_x;
  logic [15:0]            src_y;
  logic [15:0]            src_w;
  logic [15:0]            src_h;
  modport source (output valid, pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, angle,
                  src_x, src_y, src_w, src_h, input ready);
  modport sink   (input valid, pos_x, pos_y, size_w, size_h, pivot_x, pivot_y, angle,
                  src_x, src_y, src_w, src_h, output ready);
endinterface

/* rtl/sqvs_out_if.sv */
// Vertex output channel: valid/ready handshake and one vertex.
// No dependencies.
interface sqvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] vert_x;
  logic signed [19:0] vert_y;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [31:0]        color;
  logic [1:0]         corner;
  logic               last;
  modport source (output valid, vert_x, vert_y, tex_u, tex_v, color, corner, last,
                  input ready);
  modport sink   (input valid, vert_x, vert_y, tex_u, tex_v, color, corner, last,
                  output ready);
endinterface

/* rtl/sqvs_pipe.sv */
// Per-vertex datapath: NSTG register stages running the trig, rotation and
// texture coordinate divider side by side. Depends on sqvs_pkg.
module sqvs_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_vld,
  input  sqvs_pkg::vtx_t in_d,
  output logic           out_vld,
  output sqvs_pkg::vtx_t out_d
);
  import sqvs_pkg::*;

  logic [NSTG:1] vld_r;
  vtx_t          stg_r [1:NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) stg_r[1] <= in_d;
  end

  for (genvar i = 2; i <= NSTG; i++) begin : g_stg
    vtx_t stg_nxt;
    always_comb stg_nxt = stage_fn(stg_r[i-1], i);
    always_ff @(posedge clk) begin
      if (adv) stg_r[i] <= stg_nxt;
    end
  end

  assign out_vld = vld_r[NSTG];
  assign out_d   = stg_r[NSTG];
endmodule

/* rtl/sprite_quad_vertex_setup.sv */
// Top level of the sprite quad vertex setup block: configuration registers,
// sprite-to-vertex serialiser and the vertex datapath.
// Depends on sqvs_pkg, sqvs_in_if, sqvs_out_if, sqvs_pipe.
//
//   channel   | dir | handshake       | carries
//   ----------+-----+-----------------+-------------------------------------
//   in_spr    | in  | valid/ready     | one sprite per transaction
//   out_vtx   | out | valid/ready     | one vertex per transaction, 4/sprite
//   cfg_*     | in  | write enable    | register index and data, no wait
//
// A sprite occupies the serialiser while its four corners are issued in turn,
// and the block takes no new sprite while it is busy; the next sprite is taken
// in the cycle the fourth corner leaves the serialiser. Each vertex then runs
// through the datapath stages, set by the 17-step texture coordinate divider.
// Reset clears the configuration to its defaults and empties all stages.
// A stall on out_vtx freezes every stage; nothing is dropped or repeated.
module sprite_quad_vertex_setup (
  input  logic        clk,
  input  logic        rst_n,
  sqvs_in_if.sink     in_spr,
  sqvs_out_if.source  out_vtx,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import sqvs_pkg::*;

  // Configuration registers
  logic              tex_bound_r;
  logic [SIZE_W-1:0] tex_w_r;
  logic [SIZE_W-1:0] tex_h_r;
  logic              flip_r;
  logic [31:0]       tint_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_bound_r <= 1'b0;
      tex_w_r     <= SIZE_W'(1);
      tex_h_r     <= SIZE_W'(1);
      flip_r      <= 1'b0;
      tint_r      <= '1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TEX_BOUND:  tex_bound_r <= cfg_data[0];
        REG_TEX_WIDTH:  tex_w_r     <= cfg_data[SIZE_W-1:0];
        REG_TEX_HEIGHT: tex_h_r     <= cfg_data[SIZE_W-1:0];
        REG_FLIP_V:     flip_r      <= cfg_data[0];
        REG_TINT:       tint_r      <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Serialiser: hold one sprite, issue its four corners in turn
  logic                  busy_r;
  logic [1:0]            k_r;
  logic signed [19:0]    px_r, py_r, ox_r, oy_r;
  logic [15:0]           w_r, h_r, sx_r, sy_r, sw_r, sh_r;
  logic [ANGLE_BITS-1:0] ang_r;
  logic                  adv;
  logic                  acc;
  logic                  pipe_vld;
  vtx_t                  pipe_q;

  assign adv          = !pipe_vld || out_vtx.ready;
  assign in_spr.ready = !busy_r || (adv && k_r == 2'd3);
  assign acc          = in_spr.valid && in_spr.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (acc) begin
      // with no texture bound, take the sprite and drop it
      busy_r <= tex_bound_r;
      k_r    <= '0;
    end else if (adv && busy_r) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px_r  <= in_spr.pos_x;
      py_r  <= in_spr.pos_y;
      ox_r  <= in_spr.pivot_x;
      oy_r  <= in_spr.pivot_y;
      w_r   <= in_spr.size_w;
      h_r   <= in_spr.size_h;
      ang_r <= in_spr.angle;
      sx_r  <= in_spr.src_x;
      sy_r  <= in_spr.src_y;
      sw_r  <= in_spr.src_w;
      sh_r  <= in_spr.src_h;
    end
  end

  // Corner set-up: offsets, quarter-wave arguments and divider operands
  logic                  cx, cy;
  logic [ANGLE_BITS-1:0] ang_c;
  logic [15:0]           arg_s, arg_c;
  logic [16:0]           edge_u, edge_v;
  logic [SIZE_W-1:0]     sz_u, sz_v;
  vtx_t                  vtx_d;

  always_comb begin
    cx     = k_r[0] ^ k_r[1];
    cy     = !k_r[1];
    ang_c  = ang_r + ANGLE_BITS'(QSIZE);
    arg_s  = trig_arg(ang_r);
    arg_c  = trig_arg(ang_c);
    edge_u = cx ? 17'(sx_r) + 17'(sw_r) : 17'(sx_r);
    // bottom row takes the far edge unless flipped
    edge_v = (cy ^ flip_r) ? 17'(sy_r) + 17'(sh_r) : 17'(sy_r);
    sz_u   = (tex_w_r == '0) ? SIZE_W'(1) : tex_w_r;
    sz_v   = (tex_h_r == '0) ? SIZE_W'(1) : tex_h_r;

    vtx_d        = '0;
    vtx_d.corner = k_r;
    vtx_d.pxo    = 21'(px_r) + 21'(ox_r);
    vtx_d.pyo    = 21'(py_r) + 21'(oy_r);
    vtx_d.dx     = (cx ? $signed({6'd0, w_r}) : 22'sd0) - 22'(ox_r);
    vtx_d.dy     = (cy ? $signed({6'd0, h_r}) : 22'sd0) - 22'(oy_r);
    vtx_d.neg_s  = arg_s[15];
    vtx_d.t_s    = arg_s[14:0];
    vtx_d.neg_c  = arg_c[15];
    vtx_d.t_c    = arg_c[14:0];
    vtx_d.den_u  = DEN_W'(sz_u) << COORD_FRAC_BITS;
    vtx_d.den_v  = DEN_W'(sz_v) << COORD_FRAC_BITS;
    // numerator edge * 2^16 plus half the divisor for round half up
    vtx_d.rem_u  = (REM_W'(edge_u) << 16) + REM_W'(vtx_d.den_u >> 1);
    vtx_d.rem_v  = (REM_W'(edge_v) << 16) + REM_W'(vtx_d.den_v >> 1);
  end

  sqvs_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (busy_r),
    .in_d    (vtx_d),
    .out_vld (pipe_vld),
    .out_d   (pipe_q)
  );

  // Last stage is the output register
  assign out_vtx.valid  = pipe_vld;
  assign out_vtx.vert_x = pipe_q.vx;
  assign out_vtx.vert_y = pipe_q.vy;
  assign out_vtx.tex_u  = pipe_q.ovf_u ? UV_MAX : pipe_q.q_u;
  assign out_vtx.tex_v  = pipe_q.ovf_v ? UV_MAX : pipe_q.q_v;
  assign out_vtx.color  = tint_r;
  assign out_vtx.corner = pipe_q.corner;
  assign out_vtx.last   = (pipe_q.corner == 2'd3);
endmodule
